### hw/rtl/lsmn_pkg.sv
// Package for the line sensor min/max normalizer.
// Holds the shared constants and the operation codes used by the front and back ends.
// No dependencies.
package lsmn_pkg;

  localparam int NUM_IN_CH       = 5;
  localparam int DEF_CHANNELS    = 5;
  localparam int DEF_SAMPLE_BITS = 12;
  localparam int FULL_SCALE      = 1000;
  localparam int LEVEL_BITS      = 10;
  localparam int MODE_BITS       = 2;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [MODE_BITS-1:0] {
    OP_CLEAR   = 2'd0,
    OP_CAL     = 2'd1,
    OP_MEASURE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

endpackage

### hw/rtl/lsmn_front.sv
// Front end of the normalizer: accepts input transfers and classifies them.
// Drops no-operation items and packs the rest into queue entries.
// Depends on lsmn_pkg.
module lsmn_front #(
  parameter int CHANNELS    = lsmn_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = lsmn_pkg::DEF_SAMPLE_BITS,
  parameter int WIDTH       = lsmn_pkg::MODE_BITS + 2 * CHANNELS * SAMPLE_BITS
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsmn_pkg::MODE_BITS-1:0] mode,
  input  logic [SAMPLE_BITS-1:0]       first  [lsmn_pkg::NUM_IN_CH],
  input  logic [SAMPLE_BITS-1:0]       second [lsmn_pkg::NUM_IN_CH],
  input  logic                         q_full,
  output logic                         q_push,
  output logic [WIDTH-1:0]             q_data
);
  import lsmn_pkg::*;

  op_t op;

  assign op       = op_t'(mode);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (op != OP_NOP);

  always_comb begin
    q_data = '0;
    q_data[MODE_BITS-1:0] = op;
    for (int c = 0; c < CHANNELS; c++) begin
      q_data[MODE_BITS + c * SAMPLE_BITS +: SAMPLE_BITS]              = first[c];
      q_data[MODE_BITS + (CHANNELS + c) * SAMPLE_BITS +: SAMPLE_BITS] = second[c];
    end
  end

endmodule

### hw/rtl/lsmn_queue.sv
// Short first-in first-out queue between the front and back ends.
// Generic in width and depth; holds entries in registers.
// Depends on lsmn_pkg for its default depth.
module lsmn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lsmn_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import lsmn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lsmn_back.sv
// Back end of the normalizer: holds the calibration window of each channel and
// carries out clear, calibration and measurement entries taken from the queue.
// Depends on lsmn_pkg.
module lsmn_back #(
  parameter int CHANNELS    = lsmn_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = lsmn_pkg::DEF_SAMPLE_BITS,
  parameter int WIDTH       = lsmn_pkg::MODE_BITS + 2 * CHANNELS * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [WIDTH-1:0]              q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level [lsmn_pkg::NUM_IN_CH]
);
  import lsmn_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int NW    = SB + LEVEL_BITS;
  localparam int DW    = SB + LEVEL_BITS - 1;
  localparam int LANES = 2 * CHANNELS;
  localparam int CW    = $clog2(LEVEL_BITS);
  localparam logic [SB:0] EMPTY_MIN = {1'b1, {SB{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [SB:0]     chan_min  [CHANNELS];
  logic [SB-1:0]   chan_max  [CHANNELS];
  logic [SB-1:0]   samp      [LANES];
  logic [SB-1:0]   diff      [LANES];
  logic [NW-1:0]   num       [LANES];
  logic [DW-1:0]   dsh       [LANES];
  logic [LEVEL_BITS-1:0] quo [LANES];

  op_t             q_op;
  logic [SB-1:0]   q_samp    [LANES];
  logic [SB-1:0]   diff_next [LANES];
  logic [SB-1:0]   span_next [LANES];
  logic            ge        [LANES];
  logic [LEVEL_BITS:0] sum   [NUM_IN_CH];

  assign q_op  = op_t'(q_data[MODE_BITS-1:0]);
  assign q_pop = (state == S_IDLE) && !q_empty;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int CH = (l < CHANNELS) ? l : l - CHANNELS;
    logic          win_ok;
    logic [SB-1:0] lo;
    logic [SB-1:0] xc;

    assign q_samp[l] = q_data[MODE_BITS + l * SB +: SB];
    assign win_ok    = {1'b0, chan_max[CH]} > chan_min[CH];
    assign lo        = chan_min[CH][SB-1:0];

    always_comb begin
      if (samp[l] < lo) begin
        xc = lo;
      end else if (samp[l] > chan_max[CH]) begin
        xc = chan_max[CH];
      end else begin
        xc = samp[l];
      end
      diff_next[l] = win_ok ? xc - lo : '0;
      span_next[l] = win_ok ? chan_max[CH] - lo : SB'(1);
    end

    assign ge[l] = num[l] >= {1'b0, dsh[l]};
  end

  for (genvar c = 0; c < NUM_IN_CH; c++) begin : g_sum
    if (c < CHANNELS) begin : g_used
      assign sum[c] = {1'b0, quo[c]} + {1'b0, quo[c + CHANNELS]};
    end else begin : g_unused
      assign sum[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_min[c] <= EMPTY_MIN;
        chan_max[c] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_op)
              OP_CLEAR: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  chan_min[c] <= EMPTY_MIN;
                  chan_max[c] <= '0;
                end
              end
              OP_CAL: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (chan_max[c] < q_samp[c]) begin
                    chan_max[c] <= q_samp[c];
                  end
                  if (chan_min[c] > {1'b0, q_samp[c]}) begin
                    chan_min[c] <= {1'b0, q_samp[c]};
                  end
                end
              end
              OP_MEASURE: begin
                samp  <= q_samp;
                state <= S_PREP;
              end
              default: begin
              end
            endcase
          end
        end
        S_PREP: begin
          for (int l = 0; l < LANES; l++) begin
            diff[l] <= diff_next[l];
            dsh[l]  <= {span_next[l], {(LEVEL_BITS - 1){1'b0}}};
          end
          state <= S_MUL;
        end
        S_MUL: begin
          for (int l = 0; l < LANES; l++) begin
            num[l] <= NW'(diff[l]) * NW'(FULL_SCALE);
            quo[l] <= '0;
          end
          cnt   <= CW'(LEVEL_BITS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            if (ge[l]) begin
              num[l] <= num[l] - {1'b0, dsh[l]};
            end
            quo[l] <= {quo[l][LEVEL_BITS-2:0], ge[l]};
            dsh[l] <= dsh[l] >> 1;
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            for (int c = 0; c < NUM_IN_CH; c++) begin
              level[c] <= sum[c][LEVEL_BITS:1];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/line_sensor_minmax_normalizer.sv
// Top level of the line sensor min/max normalizer.
// Instantiates lsmn_front, lsmn_queue and lsmn_back; depends on lsmn_pkg.
//
// Each input transfer carries a mode and two sets of raw reflectance samples. A clear
// empties every channel's calibration window, a calibration sample widens it with the
// first set, and a measurement scales both sets to 0..1000 within the window and returns
// the floored average per channel as one result transfer; no-operation items are dropped
// at the front. Items pass through a two-entry queue, so the input keeps taking
// transfers while the queue has room, also while the back end works or the output is
// stalled. A clear or calibration item is carried out in the idle state. A measurement
// passes the prepare, multiply and divide states, the last driving the ten-step restoring
// divider in each of the ten sample lanes, and waits in the done state while stalled.
module line_sensor_minmax_normalizer #(
  parameter int CHANNELS    = lsmn_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = lsmn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lsmn_pkg::MODE_BITS-1:0] mode,
  input  logic [SAMPLE_BITS-1:0]         first_ch0,
  input  logic [SAMPLE_BITS-1:0]         first_ch1,
  input  logic [SAMPLE_BITS-1:0]         first_ch2,
  input  logic [SAMPLE_BITS-1:0]         first_ch3,
  input  logic [SAMPLE_BITS-1:0]         first_ch4,
  input  logic [SAMPLE_BITS-1:0]         second_ch0,
  input  logic [SAMPLE_BITS-1:0]         second_ch1,
  input  logic [SAMPLE_BITS-1:0]         second_ch2,
  input  logic [SAMPLE_BITS-1:0]         second_ch3,
  input  logic [SAMPLE_BITS-1:0]         second_ch4,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch0,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch1,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch2,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch3,
  output logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch4
);
  import lsmn_pkg::*;

  localparam int WIDTH = MODE_BITS + 2 * CHANNELS * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] first  [NUM_IN_CH];
  logic [SAMPLE_BITS-1:0] second [NUM_IN_CH];
  logic [LEVEL_BITS-1:0]  level  [NUM_IN_CH];
  logic                   q_full;
  logic                   q_push;
  logic [WIDTH-1:0]       q_push_data;
  logic                   q_pop;
  logic [WIDTH-1:0]       q_pop_data;
  logic                   q_empty;

  assign first[0]  = first_ch0;
  assign first[1]  = first_ch1;
  assign first[2]  = first_ch2;
  assign first[3]  = first_ch3;
  assign first[4]  = first_ch4;
  assign second[0] = second_ch0;
  assign second[1] = second_ch1;
  assign second[2] = second_ch2;
  assign second[3] = second_ch3;
  assign second[4] = second_ch4;

  assign level_ch0 = level[0];
  assign level_ch1 = level[1];
  assign level_ch2 = level[2];
  assign level_ch3 = level[3];
  assign level_ch4 = level[4];

  lsmn_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WIDTH       (WIDTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .first    (first),
    .second   (second),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  lsmn_queue #(
    .WIDTH (WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  lsmn_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WIDTH       (WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_pop_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level)
  );

endmodule

### hw/rtl/lsmn_checker.sv
// Checker for the line sensor min/max normalizer, watching its ports only.
// Bound to line_sensor_minmax_normalizer at the end of this file; depends on lsmn_pkg.
module lsmn_checker #(
  parameter int CHANNELS = lsmn_pkg::DEF_CHANNELS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch0,
  input logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch1,
  input logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch2,
  input logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch3,
  input logic [lsmn_pkg::LEVEL_BITS-1:0] level_ch4
);
  import lsmn_pkg::*;

  localparam logic [LEVEL_BITS-1:0] TOP = LEVEL_BITS'(FULL_SCALE);

  // A stalled result must hold its valid and its levels.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level_ch0) && $stable(level_ch1)
      && $stable(level_ch2) && $stable(level_ch3) && $stable(level_ch4))
    else $error("result changed while stalled");

  // Every level delivered lies within the full scale.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_ch0 <= TOP && level_ch1 <= TOP && level_ch2 <= TOP
      && level_ch3 <= TOP && level_ch4 <= TOP)
    else $error("level above full scale");

  // The outer right channel reads zero when it is not configured.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CHANNELS < NUM_IN_CH) |-> level_ch4 == '0)
    else $error("unused channel gave a non-zero level");

  // After reset the queue is empty, so the input is not stalled, and no result is pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind line_sensor_minmax_normalizer lsmn_checker #(
  .CHANNELS (CHANNELS)
) u_lsmn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .level_ch0 (level_ch0),
  .level_ch1 (level_ch1),
  .level_ch2 (level_ch2),
  .level_ch3 (level_ch3),
  .level_ch4 (level_ch4)
);
